// ===== hdl/swtl_pkg.sv =====
// shared types and constants for the sliding window token limiter
`timescale 1ns / 1ps
`default_nettype none

package swtl_pkg;

  // fixed field widths
  localparam int unsigned STAMP_W   = 48;
  localparam int unsigned TOKEN_W   = 20;
  localparam int unsigned LIMIT_W   = 32;
  localparam int unsigned WSUM_W    = 28;
  localparam int unsigned CFG_IDX_W = 2;

  // default store depth
  localparam int unsigned DEPTH_DEF = 256;

  // register reset values
  localparam logic [LIMIT_W-1:0] TOKEN_LIMIT_RST = 32'd90000;
  localparam logic [LIMIT_W-1:0] WINDOW_RST      = 32'd60000;

  // largest value shown on window_sum
  localparam logic [WSUM_W-1:0] WSUM_MAX = {WSUM_W{1'b1}};

  // request kinds
  localparam logic CMD_EVENT = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  // result status codes
  localparam logic STAT_ANSWER = 1'b0;
  localparam logic STAT_REJECT = 1'b1;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TOKEN_LIMIT = 2'd0,
    CFG_WINDOW      = 2'd1
  } cfg_reg_e;

  // sequencer states
  typedef enum logic {
    ST_IDLE,
    ST_CHECK
  } state_e;

endpackage

`default_nettype wire

// ===== hdl/sliding_window_token_limiter_core.sv =====
// top level of the sliding window token limiter: event store, expiry sequencer, results
//
//  channel   | direction | handshake                 | payload
//  ----------+-----------+---------------------------+-------------------------------------
//  request   | in        | start_i, busy_o           | cmd_i, stamp_i, token_count_i
//  result    | out       | done_o (one-cycle strobe) | status_o, window_sum_o, throttle_o,
//            |           |                           | query_stamp_o
//  config    | in        | cfg_valid_i, cfg_ready_o  | cfg_index_i, cfg_data_i
//
// an event request is handled without leaving idle; busy_o stays low, so a new request can follow at once.
// a query removes the expired entries at the head of the store, then answers: the store has one
// registered read port and the shared add/compare unit retires one head entry per cycle.
// results appear on the cycle after the decision and must be taken then.
// reset clears pointers, count and sum; store contents stay undefined until written.
// the config port is always ready.
`timescale 1ns / 1ps
`default_nettype none

module sliding_window_token_limiter_core
  import swtl_pkg::*;
#(
  parameter int unsigned DEPTH = DEPTH_DEF
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  // request channel
  input  wire logic                 start_i,
  output logic                      busy_o,
  input  wire logic                 cmd_i,
  input  wire logic [STAMP_W-1:0]   stamp_i,
  input  wire logic [TOKEN_W-1:0]   token_count_i,
  // result channel
  output logic                      done_o,
  output logic                      status_o,
  output logic [WSUM_W-1:0]         window_sum_o,
  output logic                      throttle_o,
  output logic [STAMP_W-1:0]        query_stamp_o,
  // configuration channel
  input  wire logic                 cfg_valid_i,
  output logic                      cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [LIMIT_W-1:0]   cfg_data_i
);

  localparam int unsigned PTR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W   = $clog2(DEPTH + 1);
  localparam int unsigned SUM_W   = TOKEN_W + PTR_W;
  localparam int unsigned EXT_W   = (SUM_W > LIMIT_W) ? SUM_W : LIMIT_W;
  localparam int unsigned ENTRY_W = STAMP_W + TOKEN_W;

  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  state_e               state_q, state_d;
  logic [PTR_W-1:0]     head_q, head_d, tail_q, tail_d;
  logic [CNT_W-1:0]     count_q, count_d;
  logic [SUM_W-1:0]     sum_q, sum_d;
  logic [LIMIT_W-1:0]   limit_q, window_q;
  logic [STAMP_W-1:0]   qstamp_q, qstamp_d;

  logic [ENTRY_W-1:0]   mem_q [DEPTH];
  logic [ENTRY_W-1:0]   rd_q;
  logic [PTR_W-1:0]     rd_addr;
  logic                 wr_en;

  logic                 done_q, done_d;
  logic                 status_q, status_d;
  logic [WSUM_W-1:0]    wsum_q, wsum_d;
  logic                 thr_q, thr_d;
  logic [STAMP_W-1:0]   ostamp_q, ostamp_d;

  logic [STAMP_W-1:0]   head_stamp;
  logic [TOKEN_W-1:0]   head_tokens;
  logic [PTR_W-1:0]     head_nxt, tail_nxt;
  logic [STAMP_W:0]     expire_at;
  logic                 expired;
  logic [EXT_W-1:0]     sum_ext;
  logic [WSUM_W-1:0]    sum_sat;
  logic                 sum_thr;

  assign cfg_ready_o = 1'b1;
  assign busy_o      = (state_q != ST_IDLE);

  // head entry from the registered read port
  assign head_stamp  = rd_q[ENTRY_W-1:TOKEN_W];
  assign head_tokens = rd_q[TOKEN_W-1:0];

  // pointer increments with wrap
  assign head_nxt = (head_q == PTR_LAST) ? '0 : head_q + 1'b1;
  assign tail_nxt = (tail_q == PTR_LAST) ? '0 : tail_q + 1'b1;

  // shared expiry compare at 49 bits
  assign expire_at = {1'b0, head_stamp} + (STAMP_W + 1)'(window_q);
  assign expired   = expire_at < {1'b0, qstamp_q};

  // saturated sum and throttle flag
  assign sum_ext = EXT_W'(sum_q);
  assign sum_sat = (sum_ext > EXT_W'(WSUM_MAX)) ? WSUM_MAX : sum_ext[WSUM_W-1:0];
  assign sum_thr = (sum_ext >= EXT_W'(limit_q));

  // sequencer next state and datapath control
  always_comb begin
    state_d  = state_q;
    head_d   = head_q;
    tail_d   = tail_q;
    count_d  = count_q;
    sum_d    = sum_q;
    qstamp_d = qstamp_q;
    rd_addr  = head_q;
    wr_en    = 1'b0;
    done_d   = 1'b0;
    status_d = status_q;
    wsum_d   = wsum_q;
    thr_d    = thr_q;
    ostamp_d = ostamp_q;
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          if (cmd_i == CMD_EVENT) begin
            if (count_q == CNT_FULL) begin
              done_d   = 1'b1;
              status_d = STAT_REJECT;
              wsum_d   = sum_sat;
              thr_d    = sum_thr;
              ostamp_d = stamp_i;
            end else begin
              wr_en   = 1'b1;
              tail_d  = tail_nxt;
              count_d = count_q + 1'b1;
              sum_d   = sum_q + SUM_W'(token_count_i);
            end
          end else begin
            qstamp_d = stamp_i;
            state_d  = ST_CHECK;
          end
        end
      end
      ST_CHECK: begin
        if ((count_q != '0) && expired) begin
          head_d  = head_nxt;
          rd_addr = head_nxt;
          count_d = count_q - 1'b1;
          sum_d   = sum_q - SUM_W'(head_tokens);
        end else begin
          done_d   = 1'b1;
          status_d = STAT_ANSWER;
          wsum_d   = sum_sat;
          thr_d    = sum_thr;
          ostamp_d = qstamp_q;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      head_q  <= '0;
      tail_q  <= '0;
      count_q <= '0;
      sum_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      tail_q  <= tail_d;
      count_q <= count_d;
      sum_q   <= sum_d;
      done_q  <= done_d;
    end
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q  <= TOKEN_LIMIT_RST;
      window_q <= WINDOW_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_TOKEN_LIMIT: limit_q  <= cfg_data_i;
        CFG_WINDOW:      window_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    qstamp_q <= qstamp_d;
    status_q <= status_d;
    wsum_q   <= wsum_d;
    thr_q    <= thr_d;
    ostamp_q <= ostamp_d;
  end

  // event store, one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[tail_q] <= {stamp_i, token_count_i};
    end
    rd_q <= mem_q[rd_addr];
  end

  assign done_o        = done_q;
  assign status_o      = status_q;
  assign window_sum_o  = wsum_q;
  assign throttle_o    = thr_q;
  assign query_stamp_o = ostamp_q;

endmodule

`default_nettype wire

// ===== hdl/swtl_checker.sv =====
// port-level checks for the sliding window token limiter, bound to the top level
`timescale 1ns / 1ps
`default_nettype none

module swtl_checker
  import swtl_pkg::*;
(
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               start_i,
  input wire logic               busy_o,
  input wire logic               cmd_i,
  input wire logic [STAMP_W-1:0] stamp_i,
  input wire logic               done_o,
  input wire logic               status_o,
  input wire logic [STAMP_W-1:0] query_stamp_o
);

  // an event request never makes the block busy
  a_event_no_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && cmd_i == CMD_EVENT) |=> !busy_o)
    else $error("event request left the block busy");

  // a query request always starts the expiry walk
  a_query_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && cmd_i == CMD_QUERY) |=> busy_o)
    else $error("query request did not start the walk");

  // a result only shows while idle
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy_o)
    else $error("result strobe while busy");

  // a reject answers the event request of the previous cycle and echoes its stamp
  a_reject_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o == STAT_REJECT) |->
      ($past(start_i && !busy_o && cmd_i == CMD_EVENT) && query_stamp_o == $past(stamp_i)))
    else $error("reject without a matching event request");

  // a query answer follows the end of a walk
  a_answer_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o == STAT_ANSWER) |-> $past(busy_o))
    else $error("query answer without a walk");

endmodule

bind sliding_window_token_limiter_core swtl_checker u_swtl_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .start_i       (start_i),
  .busy_o        (busy_o),
  .cmd_i         (cmd_i),
  .stamp_i       (stamp_i),
  .done_o        (done_o),
  .status_o      (status_o),
  .query_stamp_o (query_stamp_o)
);

`default_nettype wire
